### hw/rtl/stream_substring_replace_assert.svh
// Assertion macros shared by the find-and-replace RTL.
`ifndef STREAM_SUBSTRING_REPLACE_ASSERT_SVH
`define STREAM_SUBSTRING_REPLACE_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define SSR_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define SSR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define SSR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ssr_pkg.sv
package ssr_pkg;

  // Default sizes of the window and of the replacement.
  localparam int SSR_MAX_PATTERN     = 8;
  localparam int SSR_MAX_REPLACEMENT = 8;

  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_LEN_W = 4;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_BYTES      = 2'd0,
    CFG_PATTERN_LENGTH     = 2'd1,
    CFG_REPLACEMENT_BYTES  = 2'd2,
    CFG_REPLACEMENT_LENGTH = 2'd3
  } cfg_idx_t;

  // Controls for one window cell.
  typedef struct packed {
    logic load;   // a request is accepted this cycle
    logic put;    // the incoming byte lands in this cell
    logic shift;  // take the neighbour's byte (oldest byte leaves)
    logic cmp;    // this cell lies inside the pattern length
  } win_ctl_t;

  // Controls for one output queue cell.
  typedef struct packed {
    logic load;   // take a freshly produced result
    logic shift;  // head was taken, move one place down
  } q_ctl_t;

  // One result entry.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              present;
    logic              last;
    logic              done;
  } res_t;

endpackage

### hw/rtl/ssr_window_cell.sv
module ssr_window_cell (
  input  logic                      clk,
  input  ssr_pkg::win_ctl_t         ctl,
  input  logic [ssr_pkg::BYTE_W-1:0] in_byte,
  input  logic [ssr_pkg::BYTE_W-1:0] pat_byte,
  input  logic [ssr_pkg::BYTE_W-1:0] nbr_byte,
  output logic [ssr_pkg::BYTE_W-1:0] cur_byte,
  output logic                      eq
);
  import ssr_pkg::*;

  logic [BYTE_W-1:0] byte_r;

  // Window content as seen after the incoming byte is written.
  assign cur_byte = ctl.put ? in_byte : byte_r;

  // Cells beyond the pattern length never spoil a match.
  assign eq = ctl.cmp ? (cur_byte == pat_byte) : 1'b1;

  // On a mismatch the window moves one place towards the head.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      if (ctl.shift) begin
        byte_r <= nbr_byte;
      end else if (ctl.put) begin
        byte_r <= in_byte;
      end
    end
  end

endmodule

### hw/rtl/ssr_queue_cell.sv
module ssr_queue_cell (
  input  logic            clk,
  input  ssr_pkg::q_ctl_t ctl,
  input  ssr_pkg::res_t   new_ent,
  input  ssr_pkg::res_t   nbr_ent,
  output ssr_pkg::res_t   ent
);
  import ssr_pkg::*;

  res_t ent_r;

  assign ent = ent_r;

  // A new result has priority; otherwise follow the queue forward.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      ent_r <= new_ent;
    end else if (ctl.shift) begin
      ent_r <= nbr_ent;
    end
  end

endmodule

### hw/rtl/stream_substring_replace.sv
// Results of an accepted request are registered into the queue behind those still waiting.
// Throughput: one byte per cycle while each request yields at most one result and out_tready
// stays high; a request yielding n results sends them from the queue, one per cycle while ready.
// Input is taken while the output queue has room for the worst case of the next request.
// Reset (rst_n low, synchronous) empties window and queue, pattern length 1, no replacement.
module stream_substring_replace #(
  parameter int MAX_PATTERN     = ssr_pkg::SSR_MAX_PATTERN,
  parameter int MAX_REPLACEMENT = ssr_pkg::SSR_MAX_REPLACEMENT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Source bytes
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] in_byte
  input  logic                          in_tlast,   // end_of_string
  // Rewritten bytes
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // [7:0] out_byte
  output logic                          out_tlast,  // run_last
  output logic [1:0]                    out_tuser,  // [0] byte_present, [1] string_done
  // Configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ssr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ssr_pkg::*;

`include "stream_substring_replace_assert.svh"

  localparam int WIN = MAX_PATTERN;
  localparam int QD  = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
  localparam int FW  = $clog2(WIN + 1);
  localparam int RW  = $clog2(MAX_REPLACEMENT + 1);
  localparam int CW  = $clog2(QD + 1);
  localparam int JW  = (QD > 1) ? $clog2(QD) : 1;
  localparam int PB  = WIN * BYTE_W;
  localparam int RB  = MAX_REPLACEMENT * BYTE_W;
  localparam logic [CW:0] QD_W = (CW + 1)'(QD);

  // Configuration registers, lengths held already clamped.
  logic [PB-1:0] pat_r;
  logic [FW-1:0] plen_r;
  logic [RB-1:0] rep_r;
  logic [RW-1:0] rlen_r;

  logic [FW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic [CFG_LEN_W-1:0] cfg_len;
  logic [FW-1:0]        plen_cfg;
  logic [RW-1:0]        rlen_cfg;

  logic [FW-1:0] fill_eff, fill1;
  logic          cmp_hit, all_eq, match, eos, marker, pop, acc;
  logic [CW-1:0] n_raw, n_new, worst, base;
  logic [CW:0]   room_need, fill_after;

  logic [WIN-1:0]    eq;
  logic [BYTE_W-1:0] wcur [WIN];
  res_t              new_ent [QD];
  res_t              q_ent [QD];

  assign cfg_ready = 1'b1;
  assign eos       = in_tlast;

  // Clamp the written lengths to what the hardware holds.
  assign cfg_len = cfg_data[CFG_LEN_W-1:0];
  always_comb begin
    if (cfg_len == '0) begin
      plen_cfg = FW'(1);
    end else if (cfg_len > CFG_LEN_W'(WIN)) begin
      plen_cfg = FW'(WIN);
    end else begin
      plen_cfg = FW'(cfg_len);
    end
    if (cfg_len > CFG_LEN_W'(MAX_REPLACEMENT)) begin
      rlen_cfg = RW'(MAX_REPLACEMENT);
    end else begin
      rlen_cfg = RW'(cfg_len);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r  <= '0;
      plen_r <= FW'(1);
      rep_r  <= '0;
      rlen_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PATTERN_BYTES:      pat_r  <= cfg_data[PB-1:0];
        CFG_PATTERN_LENGTH:     plen_r <= plen_cfg;
        CFG_REPLACEMENT_BYTES:  rep_r  <= cfg_data[RB-1:0];
        CFG_REPLACEMENT_LENGTH: rlen_r <= rlen_cfg;
      endcase
    end
  end

  // Window decision for the request on the input.
  assign fill_eff = (fill_r >= plen_r) ? '0 : fill_r;
  assign fill1    = fill_eff + FW'(1);
  assign cmp_hit  = (fill1 == plen_r);
  assign all_eq   = &eq;
  assign match    = cmp_hit && all_eq;

  always_comb begin
    if (match) begin
      n_raw = CW'(rlen_r);
    end else if (cmp_hit) begin
      n_raw = eos ? CW'(plen_r) : CW'(1);
    end else begin
      n_raw = eos ? CW'(fill1) : '0;
    end
  end

  assign marker = eos && (n_raw == '0);
  assign n_new  = marker ? CW'(1) : n_raw;

  // Worst count of results the next request can cause, whatever its data.
  always_comb begin
    if (fill1 < plen_r) begin
      worst = CW'(fill1);
    end else if (CW'(plen_r) > CW'(rlen_r)) begin
      worst = CW'(plen_r);
    end else begin
      worst = CW'(rlen_r);
    end
  end

  // Handshakes.
  assign pop        = (cnt_r != '0) && out_tready;
  assign base       = cnt_r - CW'(pop);
  assign room_need  = {1'b0, base} + {1'b0, worst};
  assign fill_after = {1'b0, base} + {1'b0, n_new};
  assign in_tready  = (room_need <= QD_W);
  assign acc        = in_tvalid && in_tready;

  always_comb begin
    if (eos || match) begin
      fill_nxt = '0;
    end else if (cmp_hit) begin
      fill_nxt = plen_r - FW'(1);
    end else begin
      fill_nxt = fill1;
    end
    cnt_nxt = acc ? fill_after[CW-1:0] : base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cfg_valid && cfg_ready && (cfg_idx_t'(cfg_index) == CFG_PATTERN_LENGTH)) begin
        fill_r <= '0;
      end else if (acc) begin
        fill_r <= fill_nxt;
      end
    end
  end

  // Row of window cells.
  for (genvar k = 0; k < WIN; k++) begin : g_win
    win_ctl_t          wctl;
    logic [BYTE_W-1:0] nbr;

    assign wctl.load  = acc;
    assign wctl.put   = (fill_eff == FW'(k));
    assign wctl.shift = cmp_hit && !match;
    assign wctl.cmp   = (FW'(k) < plen_r);

    if (k < WIN - 1) begin : g_nbr
      assign nbr = wcur[k+1];
    end else begin : g_end
      assign nbr = '0;
    end

    ssr_window_cell u_cell (
      .clk      (clk),
      .ctl      (wctl),
      .in_byte  (in_tdata),
      .pat_byte (pat_r[k*BYTE_W +: BYTE_W]),
      .nbr_byte (nbr),
      .cur_byte (wcur[k]),
      .eq       (eq[k])
    );
  end

  // Results produced by this request, in order.
  for (genvar j = 0; j < QD; j++) begin : g_res
    logic [BYTE_W-1:0] rep_b, win_b;

    if (j < MAX_REPLACEMENT) begin : g_rep
      assign rep_b = rep_r[j*BYTE_W +: BYTE_W];
    end else begin : g_norep
      assign rep_b = '0;
    end

    if (j < WIN) begin : g_wb
      assign win_b = wcur[j];
    end else begin : g_nowb
      assign win_b = '0;
    end

    always_comb begin
      if (marker) begin
        new_ent[j].data = '0;
      end else if (match) begin
        new_ent[j].data = rep_b;
      end else begin
        new_ent[j].data = win_b;
      end
      new_ent[j].present = !marker;
      new_ent[j].last    = (CW'(j) == (n_new - CW'(1)));
      new_ent[j].done    = new_ent[j].last && eos;
    end
  end

  // Output queue: results are appended behind those still waiting.
  for (genvar i = 0; i < QD; i++) begin : g_q
    q_ctl_t      qctl;
    logic [CW:0] off;
    res_t        nbr;

    assign off       = {1'b0, CW'(i)} - {1'b0, base};
    assign qctl.load = acc && (CW'(i) >= base) && (off[CW-1:0] < n_new);
    assign qctl.shift = pop;

    if (i < QD - 1) begin : g_nbr
      assign nbr = q_ent[i+1];
    end else begin : g_end
      assign nbr = '0;
    end

    ssr_queue_cell u_cell (
      .clk     (clk),
      .ctl     (qctl),
      .new_ent (new_ent[off[JW-1:0]]),
      .nbr_ent (nbr),
      .ent     (q_ent[i])
    );
  end

  assign out_tvalid   = (cnt_r != '0);
  assign out_tdata    = q_ent[0].data;
  assign out_tlast    = q_ent[0].last;
  assign out_tuser[0] = q_ent[0].present;
  assign out_tuser[1] = q_ent[0].done;

  // Checks on window and queue bookkeeping.
  `SSR_ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= CW'(QD), "output queue count overrun")
  `SSR_ASSERT_ALWAYS(a_fill_bound, clk, rst_n, fill_r < plen_r, "window fill reached pattern length")
  `SSR_ASSERT_IMP(a_no_overflow, clk, rst_n, acc, fill_after <= QD_W, "accepted request overflows queue")
  `SSR_ASSERT_NXT(a_eos_flush, clk, rst_n, acc && eos, fill_r == '0, "window not empty after end of string")

endmodule

### tb/sv/tb_stream_substring_replace.sv
`timescale 1ns / 1ps

import ssr_pkg::*;

// Follows the rewritten string that the block should produce and checks its results.
class rewrite_tracker;
  logic [63:0] pattern_word;
  logic [3:0]  pattern_len;
  logic [63:0] subst_word;
  logic [3:0]  subst_len;
  logic [7:0]  held [8];
  int unsigned held_count;
  res_t        pending_bytes [$];
  int          mismatch_count;

  function new();
    pattern_word   = '0;
    pattern_len    = 4'd1;
    subst_word     = '0;
    subst_len      = '0;
    foreach (held[n]) held[n] = 8'h00;
    held_count     = 0;
    mismatch_count = 0;
  endfunction

  function int pending();
    return pending_bytes.size();
  endfunction

  // A new pattern length empties the window, whatever it held.
  function void write_reg(cfg_idx_t idx, logic [63:0] value);
    case (idx)
      CFG_PATTERN_BYTES:      pattern_word = value;
      CFG_PATTERN_LENGTH: begin
        pattern_len = value[3:0];
        held_count  = 0;
      end
      CFG_REPLACEMENT_BYTES:  subst_word = value;
      CFG_REPLACEMENT_LENGTH: subst_len = value[3:0];
      default: ;
    endcase
  endfunction

  // Works out the results of one accepted source byte and queues them.
  function void note_source_byte(logic [7:0] b, logic eos);
    int unsigned plen;
    int unsigned rlen;
    int unsigned k;
    bit          hit;
    res_t        step_q [$];
    plen = (pattern_len == 0) ? 1 :
           ((pattern_len > SSR_MAX_PATTERN) ? SSR_MAX_PATTERN : pattern_len);
    rlen = (subst_len > SSR_MAX_REPLACEMENT) ? SSR_MAX_REPLACEMENT : subst_len;
    if (held_count >= plen) held_count = 0;
    held[held_count] = b;
    held_count++;

    // A full window either matches and is replaced, or loses its oldest byte.
    if (held_count == plen) begin
      hit = 1'b1;
      for (k = 0; k < plen; k++)
        if (held[k] != pattern_word[8*k +: 8]) hit = 1'b0;
      if (hit) begin
        for (k = 0; k < rlen; k++)
          step_q.push_back(res_t'{subst_word[8*k +: 8], 1'b1, 1'b0, 1'b0});
        held_count = 0;
      end else begin
        step_q.push_back(res_t'{held[0], 1'b1, 1'b0, 1'b0});
        for (k = 1; k < 8; k++) held[k-1] = held[k];
        held_count--;
      end
    end

    // End of string flushes the window; an empty ending still gives a marker.
    if (eos) begin
      for (k = 0; k < held_count; k++)
        step_q.push_back(res_t'{held[k], 1'b1, 1'b0, 1'b0});
      held_count = 0;
      if (step_q.size() == 0) step_q.push_back(res_t'{8'h00, 1'b0, 1'b0, 1'b0});
    end
    if (step_q.size() > 0) begin
      step_q[step_q.size()-1].last = 1'b1;
      if (eos) step_q[step_q.size()-1].done = 1'b1;
    end
    foreach (step_q[n]) pending_bytes.push_back(step_q[n]);
  endfunction

  task check_rewritten_byte(logic [7:0] data, logic present, logic last, logic done);
    res_t want;
    if (pending_bytes.size() == 0) begin
      flag_mismatch($sformatf("result byte %02h arrived with nothing pending", data));
      return;
    end
    want = pending_bytes.pop_front();
    if (data !== want.data)
      flag_mismatch($sformatf("out_byte %02h, expected %02h", data, want.data));
    if (present !== want.present)
      flag_mismatch($sformatf("byte_present %b, expected %b", present, want.present));
    if (last !== want.last)
      flag_mismatch($sformatf("run_last %b, expected %b", last, want.last));
    if (done !== want.done)
      flag_mismatch($sformatf("string_done %b, expected %b", done, want.done));
  endtask

  task flag_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 100) $display("%0t mismatch: %s", $time, what);
  endtask
endclass

module tb_stream_substring_replace;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 400;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;
  logic                  out_tlast;
  logic [1:0]            out_tuser;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  rewrite_tracker tracker = new();
  bit             steady       = 1'b0;
  bit             hold_off_req = 1'b0;
  int             cycles       = 0;

  // Current setting, kept so that the strings can be built to hit the pattern.
  logic [63:0] cur_pattern = '0;
  int unsigned cur_plen    = 1;
  logic [7:0]  alphabet [2];

  stream_substring_replace i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 75) return 0;
    if (roll < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side: checks every accepted result and stalls at random.
  initial begin : result_sink
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        tracker.check_rewritten_byte(out_tdata, out_tuser[0], out_tlast, out_tuser[1]);
      if (quiet > 0) begin
        quiet--;
        out_tready <= 1'b0;
      end else if (hold_off_req) begin
        // Long hold-off so that the output queue fills and the input stalls.
        hold_off_req = 1'b0;
        quiet = 79;
        out_tready <= 1'b0;
      end else begin
        quiet = pick_gap();
        out_tready <= (quiet == 0);
        if (quiet > 0) quiet--;
      end
    end
  end

  // Offers one source byte and waits until the request is taken.
  task automatic send_byte(logic [7:0] b, logic eos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_source_byte(b, eos);
  endtask

  // Waits until every expected result is out and the block has settled.
  task automatic settle_block();
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all four registers back to back; only called while the block is idle.
  task automatic load_setting(logic [63:0] pat, logic [3:0] plen,
                              logic [63:0] rep, logic [3:0] rlen);
    cfg_idx_t    regs [4];
    logic [63:0] vals [4];
    regs = '{CFG_PATTERN_BYTES, CFG_PATTERN_LENGTH, CFG_REPLACEMENT_BYTES,
             CFG_REPLACEMENT_LENGTH};
    vals = '{pat, 64'(plen), rep, 64'(rlen)};
    foreach (regs[r]) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[r];
      cfg_data  <= vals[r];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      tracker.write_reg(regs[r], vals[r]);
    end
    cfg_valid   <= 1'b0;
    cur_pattern = pat;
    cur_plen    = (plen == 0) ? 1 : ((plen > SSR_MAX_PATTERN) ? SSR_MAX_PATTERN : plen);
  endtask

  // Random setting over a two-byte alphabet, so that matches are frequent.
  task automatic random_setting();
    logic [63:0] pat;
    logic [3:0]  plen;
    logic [3:0]  rlen;
    int          roll;
    int unsigned k;
    alphabet[0] = 8'($urandom);
    alphabet[1] = 8'($urandom);
    roll = $urandom_range(0, 9);
    if (roll == 0)
      plen = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
    else if (roll < 3)
      plen = 4'($urandom_range(5, 8));
    else
      plen = 4'($urandom_range(1, 4));
    pat = {$urandom, $urandom};
    for (k = 0; k < 8; k++)
      if ($urandom_range(0, 3) != 0) pat[8*k +: 8] = alphabet[$urandom_range(0, 1)];
    rlen = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    load_setting(pat, plen, {$urandom, $urandom}, rlen);
  endtask

  // Sends a string of pattern copies, broken prefixes, alphabet bytes and noise.
  task automatic send_string(int unsigned len, bit close, output int unsigned added);
    logic [7:0]  text [$];
    int unsigned cut;
    int unsigned k;
    int          roll;
    while (text.size() < len) begin
      roll = $urandom_range(0, 9);
      if (roll < 6) begin
        cut = (roll < 4) ? cur_plen : $urandom_range(1, cur_plen);
        for (k = 0; k < cut; k++) text.push_back(cur_pattern[8*k +: 8]);
      end else if (roll < 9) begin
        text.push_back(alphabet[$urandom_range(0, 1)]);
      end else begin
        text.push_back(8'($urandom));
      end
    end
    foreach (text[n]) send_byte(text[n], close && (n == text.size() - 1));
    added = text.size();
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned chunk;
    int unsigned added;
    int unsigned phase;
    int unsigned k;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset setting deletes zero bytes: a lone zero leaves only the end marker.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);

    // Longest pattern and replacement: a full match, then a full miss and flush.
    settle_block();
    load_setting({8{8'hFF}}, 4'd8, 64'h0123_4567_89AB_CDEF, 4'd8);
    for (k = 0; k < 8; k++) send_byte(8'hFF, k == 7);
    for (k = 0; k < 7; k++) send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);

    // Zero pattern length acts as one; oversized replacement length saturates.
    settle_block();
    load_setting(64'h41, 4'd0, 64'hFEDC_BA98_7654_3210, 4'd15);
    send_byte(8'h41, 1'b1);

    // Oversized pattern length saturates; leave two bytes held in the window.
    settle_block();
    load_setting(64'h0, 4'd15, 64'h0, 4'd0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);

    // Changing the setting mid-string drops the held bytes.
    settle_block();
    load_setting(64'h6261, 4'd2, 64'h7A, 4'd1);
    send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b1);

    // Random phases, each under a fresh setting.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      settle_block();
      random_setting();
      steady = (phase == 2) || ($urandom_range(0, 3) == 0);
      if (phase == 2) hold_off_req = 1'b1;
      chunk = 0;
      while (chunk < 60 && sent < RANDOM_ITEMS) begin
        send_string($urandom_range(1, 20), 1'b1, added);
        chunk += added;
        sent  += added;
      end
      // Sometimes leave a string open so that the next setting cuts it short.
      if ($urandom_range(0, 3) == 0) begin
        send_string($urandom_range(1, 6), 1'b0, added);
        sent += added;
      end
      phase++;
    end

    settle_block();
    if (tracker.mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
